// ===== design/ring_buffer_deque_top_macros.svh =====
// assertion macros used by the deque control logic
// no dependencies; taken in by rbd_ctrl, the only file that carries assertions
`ifndef RING_BUFFER_DEQUE_TOP_MACROS_SVH
`define RING_BUFFER_DEQUE_TOP_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define RBD_ASSERT_HOLDS(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define RBD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/rbd_pkg.sv =====
// types, constants and helper functions of the ring buffer deque
// no dependencies
package rbd_pkg;

  localparam int CAPACITY   = 16;
  localparam int DATA_WIDTH = 32;
  localparam int ADDR_W     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int COUNT_W    = $clog2(CAPACITY + 1);
  localparam int VALUE_W    = 32;
  localparam int FILL_W     = 5;

  typedef enum logic [1:0] {
    CMD_PUSH_FRONT = 2'd0,
    CMD_POP_FRONT  = 2'd1,
    CMD_PUSH_BACK  = 2'd2,
    CMD_POP_BACK   = 2'd3
  } command_t;

  typedef enum logic [1:0] {
    STATUS_DONE  = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_t;

  typedef enum logic {
    ST_IDLE,
    ST_READ
  } state_t;

  typedef struct packed {
    command_t                    command;
    logic signed [VALUE_W-1:0]   push_value;
  } cmd_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0]   pop_value;
    status_t                     status;
    logic [FILL_W-1:0]           fill_count;
  } rsp_t;

  typedef logic [ADDR_W-1:0]     addr_t;
  typedef logic [COUNT_W-1:0]    count_t;
  typedef logic [DATA_WIDTH-1:0] slot_t;

  function automatic addr_t wrap_inc(addr_t i);
    return (i == ADDR_W'(CAPACITY - 1)) ? '0 : i + 1'b1;
  endfunction

  function automatic addr_t wrap_dec(addr_t i);
    return (i == '0) ? ADDR_W'(CAPACITY - 1) : i - 1'b1;
  endfunction

  // sign-extend the field, then keep the stored width
  function automatic slot_t to_slot(logic signed [VALUE_W-1:0] v);
    logic signed [63:0] w;
    w = 64'(v);
    return w[DATA_WIDTH-1:0];
  endfunction

  // sign-extend the stored width, then cut to the field width
  function automatic logic signed [VALUE_W-1:0] from_slot(slot_t s);
    logic signed [DATA_WIDTH-1:0] sv;
    logic signed [63:0]           w;
    sv = s;
    w  = 64'(sv);
    return w[VALUE_W-1:0];
  endfunction

endpackage

// ===== design/ring_buffer_deque_top.sv =====
// results: a push, a dropped push or a pop on an empty deque shows its result
//   in the cycle after the command transfer; a pop that reads a slot first passes through the read state
// throughput: one command per cycle for pushes and rejected commands while rsp_stall is
//   low; a pop holds off the next command until its registered slot read has returned
// reset: pointers, count, sequencer and result valid clear; slot contents are
//   left as they are, a pop only ever reads a slot that a push has written
module ring_buffer_deque_top
  import rbd_pkg::*;
(
  input  logic clk,
  input  logic rst,
  // command channel
  input  logic cmd_valid,
  output logic cmd_stall,
  input  cmd_t cmd,
  // result channel
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  // slot ram ports
  logic  wr_en;
  addr_t wr_addr;
  slot_t wr_data;
  logic  rd_en;
  addr_t rd_addr;
  slot_t rd_data;

  // sequencer: owns front and back pointers, the element count and the
  // result register; a push writes its slot at the transfer edge, a pop
  // issues the read there and loads the read data into the result register from the read state
  rbd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data)
  );

  // slot storage; writes and reads never fall in the same cycle because each
  // taken command is either a push or a pop, and a pop is only taken once any earlier read has returned, so a pop
  // always sees the slot written by an earlier push
  rbd_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (DATA_WIDTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

endmodule

// ===== design/rbd_ram.sv =====
// slot storage: one write port, one read port with registered read data
// no dependencies
module rbd_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [$clog2(DEPTH)-1:0]   wr_addr,
  input  logic [WIDTH-1:0]           wr_data,
  input  logic                       rd_en,
  input  logic [$clog2(DEPTH)-1:0]   rd_addr,
  output logic [WIDTH-1:0]           rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== design/rbd_ctrl.sv =====
// pointers, element count, command sequencer and result register
// depends on rbd_pkg and ring_buffer_deque_top_macros.svh
`include "ring_buffer_deque_top_macros.svh"

module rbd_ctrl
  import rbd_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  cmd_valid,
  output logic  cmd_stall,
  input  cmd_t  cmd,
  output logic  rsp_valid,
  input  logic  rsp_stall,
  output rsp_t  rsp,
  output logic  wr_en,
  output addr_t wr_addr,
  output slot_t wr_data,
  output logic  rd_en,
  output addr_t rd_addr,
  input  slot_t rd_data
);

  state_t state, state_next;
  addr_t  front_index, front_index_next;
  addr_t  back_index, back_index_next;
  count_t count, count_next;
  rsp_t   rsp_next;
  logic   rsp_load;
  logic   rsp_valid_next;

  logic cmd_accept;
  logic is_push;
  logic is_front;
  logic full;
  logic empty;

  logic [ADDR_W:0] ring_sum;
  addr_t           ring_end;

  assign is_push  = (cmd.command == CMD_PUSH_FRONT) || (cmd.command == CMD_PUSH_BACK);
  assign is_front = (cmd.command == CMD_PUSH_FRONT) || (cmd.command == CMD_POP_FRONT);
  assign full     = (count == COUNT_W'(CAPACITY));
  assign empty    = (count == '0);

  // one command at a time; the result register must be free or draining
  assign cmd_stall  = (state != ST_IDLE) || (rsp_valid && rsp_stall);
  assign cmd_accept = cmd_valid && !cmd_stall;

  assign wr_data = to_slot(cmd.push_value);
  assign rd_addr = is_front ? front_index : wrap_dec(back_index);
  assign wr_addr = is_front ? wrap_dec(front_index) : back_index;
  assign wr_en   = cmd_accept && is_push && !full;
  assign rd_en   = cmd_accept && !is_push && !empty;

  always_comb begin
    state_next       = state;
    front_index_next = front_index;
    back_index_next  = back_index;
    count_next       = count;
    rsp_load         = 1'b0;
    rsp_next.pop_value  = '0;
    rsp_next.status     = STATUS_DONE;
    rsp_next.fill_count = FILL_W'(count);
    unique case (state)
      ST_IDLE: begin
        if (cmd_accept) begin
          if (is_push) begin
            rsp_load = 1'b1;
            if (full) begin
              rsp_next.status = STATUS_FULL;
            end else begin
              count_next = count + 1'b1;
              rsp_next.fill_count = FILL_W'(count_next);
              if (is_front) begin
                front_index_next = wrap_dec(front_index);
              end else begin
                back_index_next = wrap_inc(back_index);
              end
            end
          end else if (empty) begin
            rsp_load = 1'b1;
            rsp_next.pop_value = '1;
            rsp_next.status    = STATUS_EMPTY;
          end else begin
            count_next = count - 1'b1;
            state_next = ST_READ;
            if (is_front) begin
              front_index_next = wrap_inc(front_index);
            end else begin
              back_index_next = wrap_dec(back_index);
            end
          end
        end
      end
      ST_READ: begin
        // slot data arrives; count already holds the value after the pop
        rsp_load = 1'b1;
        rsp_next.pop_value = from_slot(rd_data);
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (rsp_load) begin
      rsp_valid_next = 1'b1;
    end else if (rsp_valid && !rsp_stall) begin
      rsp_valid_next = 1'b0;
    end else begin
      rsp_valid_next = rsp_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      front_index <= '0;
      back_index  <= '0;
      count       <= '0;
      rsp_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      front_index <= front_index_next;
      back_index  <= back_index_next;
      count       <= count_next;
      rsp_valid   <= rsp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp <= rsp_next;
    end
  end

  // front plus count, wrapped, must land on the back pointer
  assign ring_sum = (ADDR_W + 1)'(front_index) + (ADDR_W + 1)'(count);
  assign ring_end = (ring_sum >= (ADDR_W + 1)'(CAPACITY)) ?
                    ADDR_W'(ring_sum - (ADDR_W + 1)'(CAPACITY)) : ADDR_W'(ring_sum);

  `RBD_ASSERT_HOLDS(a_ring_consistent, clk, rst, 1'b1, ring_end == back_index, "pointers and count disagree")
  `RBD_ASSERT_HOLDS(a_count_range, clk, rst, 1'b1, count <= COUNT_W'(CAPACITY), "count beyond capacity")
  `RBD_ASSERT_HOLDS(a_read_out_free, clk, rst, state == ST_READ, !rsp_valid, "result register busy during slot read")
  `RBD_ASSERT_HOLDS(a_fill_tracks, clk, rst, rsp_valid, rsp.fill_count == FILL_W'(count), "reported fill differs from count")
  `RBD_ASSERT_NEXT(a_full_flag, clk, rst, cmd_accept && is_push && full, rsp_valid && rsp.status == STATUS_FULL, "dropped push not flagged")

endmodule
